// File: rtl/ps2md_pkg.sv
// Shared types, codes and arithmetic helpers for the PS/2 mouse packet decoder.
package ps2md_pkg;

  localparam int ACC_WIDTH = 16;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_READ  = 2'd1,
    OP_OPEN  = 2'd2,
    OP_CLOSE = 2'd3
  } op_t;

  localparam logic [1:0] PHASE_FIRST = 2'd0;
  localparam logic [1:0] PHASE_X     = 2'd1;
  localparam logic [1:0] PHASE_Y     = 2'd2;

  localparam logic KIND_EVENT  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [2:0] BTN_MASK     = 3'h7;
  localparam logic [7:0] SYNC_BIT     = 8'h08;
  localparam logic [7:0] EVENT_FLAG   = 8'h80;
  localparam logic [7:0] MOTION_MIN   = 8'h80;
  localparam logic [7:0] MOTION_FLOOR = 8'h81;

  localparam logic signed [ACC_WIDTH-1:0] CLAMP_POS = ACC_WIDTH'(127);
  localparam logic signed [ACC_WIDTH-1:0] CLAMP_NEG = -CLAMP_POS;

  typedef struct packed {
    logic                        is_open;
    logic [1:0]                  byte_phase;
    logic [7:0]                  first_byte;
    logic signed [7:0]           delta_x;
    logic [5:0]                  button_status;
    logic signed [ACC_WIDTH-1:0] accum_x;
    logic signed [ACC_WIDTH-1:0] accum_y;
  } dec_state_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        status_byte;
    logic signed [7:0] x_motion;
    logic signed [7:0] y_motion;
  } dec_result_t;

  // Fold -128 onto -127.
  function automatic logic signed [7:0] motion_of(input logic [7:0] b);
    if (b == MOTION_MIN) begin
      motion_of = MOTION_FLOOR;
    end else begin
      motion_of = b;
    end
  endfunction

  // Signed add that saturates at the accumulator range.
  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] acc,
    input logic signed [7:0]           d
  );
    logic signed [ACC_WIDTH:0] s;
    s = {acc[ACC_WIDTH-1], acc} + {{(ACC_WIDTH-7){d[7]}}, d};
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      sat_add = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                             : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      sat_add = s[ACC_WIDTH-1:0];
    end
  endfunction

  function automatic logic signed [7:0] clamp127(input logic signed [ACC_WIDTH-1:0] v);
    if (v > CLAMP_POS) begin
      clamp127 = CLAMP_POS[7:0];
    end else if (v < CLAMP_NEG) begin
      clamp127 = CLAMP_NEG[7:0];
    end else begin
      clamp127 = v[7:0];
    end
  endfunction

endpackage

// File: rtl/ps2md_step.sv
// Next-state and result logic for one decoder transaction.
module ps2md_step (
  input  ps2md_pkg::dec_state_t  cur,
  input  ps2md_pkg::op_t         op,
  input  logic [7:0]             data_byte,
  output ps2md_pkg::dec_state_t  nxt,
  output logic                   res_valid,
  output ps2md_pkg::dec_result_t res
);

  logic              [2:0] nb;
  logic              [2:0] chg;
  logic signed       [7:0] dy;

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    nb        = {cur.first_byte[0], cur.first_byte[2:1]};
    chg       = (nb ^ cur.button_status[2:0]) & ps2md_pkg::BTN_MASK;
    dy        = ps2md_pkg::motion_of(data_byte);

    unique case (op)
      ps2md_pkg::OP_READ: begin
        res_valid            = 1'b1;
        res.kind             = ps2md_pkg::KIND_REPORT;
        res.status_byte      = {1'b0, (cur.accum_x != '0) || (cur.accum_y != '0),
                                cur.button_status};
        res.x_motion         = ps2md_pkg::clamp127(cur.accum_x);
        res.y_motion         = ps2md_pkg::clamp127(cur.accum_y);
        nxt.accum_x          = '0;
        nxt.accum_y          = '0;
        nxt.button_status    = {3'b000, cur.button_status[2:0]};
      end
      ps2md_pkg::OP_OPEN: begin
        if (!cur.is_open) begin
          nxt.is_open       = 1'b1;
          nxt.button_status = '0;
          nxt.accum_x       = '0;
          nxt.accum_y       = '0;
          nxt.byte_phase    = ps2md_pkg::PHASE_FIRST;
        end
      end
      ps2md_pkg::OP_CLOSE: begin
        nxt.is_open = 1'b0;
      end
      ps2md_pkg::OP_BYTE: begin
        if (cur.is_open) begin
          case (cur.byte_phase)
            ps2md_pkg::PHASE_FIRST: begin
              nxt.first_byte = data_byte;
              if ((data_byte & ps2md_pkg::SYNC_BIT) != '0) begin
                nxt.byte_phase = ps2md_pkg::PHASE_X;
              end
            end
            ps2md_pkg::PHASE_X: begin
              nxt.delta_x    = ps2md_pkg::motion_of(data_byte);
              nxt.byte_phase = ps2md_pkg::PHASE_Y;
            end
            ps2md_pkg::PHASE_Y: begin
              nxt.button_status = {cur.button_status[5:3] | chg, nb};
              nxt.byte_phase    = ps2md_pkg::PHASE_FIRST;
              if ((cur.delta_x != '0) || (dy != '0) || (chg != '0)) begin
                nxt.accum_x     = ps2md_pkg::sat_add(cur.accum_x, cur.delta_x);
                nxt.accum_y     = ps2md_pkg::sat_add(cur.accum_y, dy);
                res_valid       = 1'b1;
                res.kind        = ps2md_pkg::KIND_EVENT;
                res.status_byte = ps2md_pkg::EVENT_FLAG | {5'b00000, nb ^ ps2md_pkg::BTN_MASK};
                res.x_motion    = cur.delta_x;
                res.y_motion    = dy;
              end
            end
            default: begin
              // Unused phase: consume the byte and resync.
              nxt.byte_phase = ps2md_pkg::PHASE_FIRST;
            end
          endcase
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// File: rtl/ps2_mouse_packet_decoder.sv
// Top level of the PS/2 mouse three-byte packet decoder.
//
// The decoder takes one transaction per cycle on the s_ side: a command in
// s_tuser (device byte, read report, open, close) and, for device bytes, the
// mouse byte in s_tdata. While open it frames button/X/Y packets, drops a
// first byte whose sync bit (bit 3) is clear, folds -128 motion to -127,
// reorders the buttons to right/middle/left, keeps sticky change bits and
// adds the motion of each non-quiet packet to two saturating signed
// accumulators. A packet with motion or a button change yields an event on
// the m_ side; a read yields a report with the status, a movement bit and
// the accumulated motion clamped to +/-127, then clears the accumulators and
// the change bits. An accepted transaction lands in the input register and
// is decoded from there straight into the result register, which presents
// its result on the m_ side. One transaction is taken every cycle as long
// as the m_ side keeps taking results. The result register holds a pending
// result while the input register still takes the next transaction.
module ps2_mouse_packet_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] status_byte, [15:8] x_motion, [23:16] y_motion
  output logic        m_tuser    // [0] kind
);

  // Input register.
  logic                  in_vld;
  ps2md_pkg::op_t        in_op;
  logic [7:0]            in_data;

  // Decoder state.
  ps2md_pkg::dec_state_t st;
  ps2md_pkg::dec_state_t st_next;

  logic                  res_valid;
  ps2md_pkg::dec_result_t res;
  logic                  advance;

  // The decode stage moves whenever the result register is free or drained.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
    if (s_tready) begin
      in_op   <= ps2md_pkg::op_t'(s_tuser);
      in_data <= s_tdata;
    end
  end

  ps2md_step u_step (
    .cur       (st),
    .op        (in_op),
    .data_byte (in_data),
    .nxt       (st_next),
    .res_valid (res_valid),
    .res       (res)
  );

  // Commit state and load the result register as the held transaction leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_vld && res_valid;
      if (in_vld) begin
        st <= st_next;
      end
    end
    if (advance && in_vld && res_valid) begin
      m_tuser <= res.kind;
      m_tdata <= {res.y_motion, res.x_motion, res.status_byte};
    end
  end

`ifndef SYNTHESIS
  // A read always leaves both accumulators cleared.
  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && in_vld && in_op == ps2md_pkg::OP_READ) |=>
      (st.accum_x == '0 && st.accum_y == '0 && st.button_status[5:3] == 3'b000))
    else $error("read did not clear accumulators or change bits");

  // A device byte while closed changes nothing.
  a_closed_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && in_vld && in_op == ps2md_pkg::OP_BYTE && !st.is_open) |=>
      $stable(st))
    else $error("state changed on a byte while closed");

  // Events carry the event flag in the status.
  a_event_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ps2md_pkg::KIND_EVENT) |-> m_tdata[7])
    else $error("event without its flag bit");

  // No result ever carries -128 motion.
  a_no_min_motion: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:8] != ps2md_pkg::MOTION_MIN &&
                  m_tdata[23:16] != ps2md_pkg::MOTION_MIN))
    else $error("motion of -128 on output");
`endif

endmodule
